// ===== design/cau_pkg.sv =====
// Shared types and codes for the complex arithmetic unit.
// Holds the operation codes and the decoded operation flags; no dependencies.
package cau_pkg;

    localparam int MODE_W = 3;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD  = 3'd0,
        MODE_SUB  = 3'd1,
        MODE_MUL  = 3'd2,
        MODE_DIV  = 3'd3,
        MODE_CONJ = 3'd4,
        MODE_NEG  = 3'd5,
        MODE_ABS2 = 3'd6,
        MODE_ABS  = 3'd7
    } t_mode;

    // Decoded operation, one flag per operation.
    typedef struct packed {
        logic add;
        logic sub;
        logic mul;
        logic div;
        logic conj;
        logic neg;
        logic abs2;
        logic mag;
    } t_op;

endpackage

// ===== design/cau_if.sv =====
// Request and result channel interfaces for the complex arithmetic unit.
// Depends on cau_pkg for the mode width.
interface cau_req_if import cau_pkg::*; #(parameter int WORD_WIDTH = 32) ();
    logic                         valid;
    logic                         ready;
    logic [MODE_W-1:0]            mode;
    logic signed [WORD_WIDTH-1:0] a_re;
    logic signed [WORD_WIDTH-1:0] a_im;
    logic signed [WORD_WIDTH-1:0] b_re;
    logic signed [WORD_WIDTH-1:0] b_im;

    modport source (output valid, mode, a_re, a_im, b_re, b_im, input ready);
    modport sink   (input valid, mode, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cau_res_if #(parameter int WORD_WIDTH = 32) ();
    logic                         valid;
    logic                         ready;
    logic signed [WORD_WIDTH-1:0] res_re;
    logic signed [WORD_WIDTH-1:0] res_im;
    logic                         overflow;
    logic                         div_zero;

    modport source (output valid, res_re, res_im, overflow, div_zero, input ready);
    modport sink   (input valid, res_re, res_im, overflow, div_zero, output ready);
endinterface

// ===== design/cau_front.sv =====
// Front end: accepts requests, decodes the mode and holds one request.
// Depends on cau_pkg and cau_req_if.
module cau_front import cau_pkg::*; #(
    parameter int WORD_WIDTH = 32,
    localparam int ITEM_W = $bits(t_op) + 4 * WORD_WIDTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    cau_req_if.sink           i_req,
    output logic              o_valid,
    output logic [ITEM_W-1:0] o_item,
    input  logic              i_ready
);

    logic              r_v;
    logic [ITEM_W-1:0] r_item;
    t_op               n_op;

    always_comb begin
        n_op = '0;
        unique case (t_mode'(i_req.mode))
            MODE_ADD:  n_op.add  = 1'b1;
            MODE_SUB:  n_op.sub  = 1'b1;
            MODE_MUL:  n_op.mul  = 1'b1;
            MODE_DIV:  n_op.div  = 1'b1;
            MODE_CONJ: n_op.conj = 1'b1;
            MODE_NEG:  n_op.neg  = 1'b1;
            MODE_ABS2: n_op.abs2 = 1'b1;
            default:   n_op.mag  = 1'b1;
        endcase
    end

    // The holding register refills in the same cycle that it drains.
    assign i_req.ready = !r_v || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_req.ready) begin
            r_v <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_item <= {n_op, i_req.a_re, i_req.a_im, i_req.b_re, i_req.b_im};
        end
    end

    assign o_valid = r_v;
    assign o_item  = r_item;

endmodule

// ===== design/cau_queue.sv =====
// Short first-in first-out queue between the front end and the back end.
// Standalone; generic width and depth.
module cau_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 4,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_ready,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_data,
    input  logic              i_ready
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [AW-1:0]     r_wr;
    logic [AW-1:0]     r_rd;
    logic [AW:0]       r_cnt;
    logic              push;
    logic              pop;

    assign o_ready = (r_cnt != (AW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== design/cau_back.sv =====
// Back end: pipelined products, restoring division and integer square root.
// Depends on cau_pkg and cau_res_if; fed from the request queue.
module cau_back import cau_pkg::*; #(
    parameter int WORD_WIDTH = 32,
    parameter int FRAC_BITS  = 16,
    localparam int ITEM_W = $bits(t_op) + 4 * WORD_WIDTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [ITEM_W-1:0] i_item,
    output logic              o_ready,
    cau_res_if.source         o_res
);

    localparam int W    = WORD_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int PW   = 2 * W;
    localparam int SW   = 2 * W + 1;
    localparam int VW   = 2 * W + 2;
    localparam int RW   = 2 * W + 2;
    localparam int NW   = 2 * W + F;
    localparam int CW   = (NW > 3 * W + 1) ? NW : 3 * W + 1;
    localparam int QW   = W + 2;
    localparam int NSTG = W + 2;

    // Saturates a wide signed value to the word; the top bit is the overflow flag.
    function automatic logic [W:0] sat_w(input logic signed [VW-1:0] v);
        logic [VW-W:0] top;
        logic [W:0]    res;
        top = v[VW-1:W-1];
        if (top == '0 || top == '1) begin
            res = {1'b0, v[W-1:0]};
        end else if (v[VW-1]) begin
            res = {1'b1, 1'b1, {(W-1){1'b0}}};
        end else begin
            res = {1'b1, 1'b0, {(W-1){1'b1}}};
        end
        return res;
    endfunction

    logic en;
    assign en      = !o_res.valid || o_res.ready;
    assign o_ready = en;

    // Stage 0: request taken from the queue.
    logic                r0_v;
    t_op                 r0_op;
    logic signed [W-1:0] r0_ar, r0_ai, r0_br, r0_bi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else if (en) begin
            r0_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            {r0_op, r0_ar, r0_ai, r0_br, r0_bi} <= i_item;
        end
    end

    // Stage 1: the six products and the results that need no product.
    logic                 r1_v;
    t_op                  r1_op;
    logic signed [PW-1:0] r1_p0, r1_p1, r1_p2, r1_p3, r1_p4, r1_p5;
    logic signed [VW-1:0] r1_vre, r1_vim;
    logic signed [W-1:0]  sq_x, sq_y;
    logic signed [VW-1:0] e_ar, e_ai, e_br, e_bi;
    logic signed [VW-1:0] n1_vre, n1_vim;

    assign sq_x = r0_op.div ? r0_br : r0_ar;
    assign sq_y = r0_op.div ? r0_bi : r0_ai;
    assign e_ar = {{(VW-W){r0_ar[W-1]}}, r0_ar};
    assign e_ai = {{(VW-W){r0_ai[W-1]}}, r0_ai};
    assign e_br = {{(VW-W){r0_br[W-1]}}, r0_br};
    assign e_bi = {{(VW-W){r0_bi[W-1]}}, r0_bi};

    always_comb begin
        n1_vre = '0;
        n1_vim = '0;
        if (r0_op.add) begin
            n1_vre = e_ar + e_br;
            n1_vim = e_ai + e_bi;
        end else if (r0_op.sub) begin
            n1_vre = e_ar - e_br;
            n1_vim = e_ai - e_bi;
        end else if (r0_op.conj) begin
            n1_vre = e_ar;
            n1_vim = -e_ai;
        end else if (r0_op.neg) begin
            n1_vre = -e_ar;
            n1_vim = -e_ai;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= r0_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_op  <= r0_op;
            r1_p0  <= r0_ar * r0_br;
            r1_p1  <= r0_ai * r0_bi;
            r1_p2  <= r0_ar * r0_bi;
            r1_p3  <= r0_ai * r0_br;
            r1_p4  <= sq_x * sq_x;
            r1_p5  <= sq_y * sq_y;
            r1_vre <= n1_vre;
            r1_vim <= n1_vim;
        end
    end

    // Stage 2: sums of products.
    logic                 r2_v;
    t_op                  r2_op;
    logic signed [SW-1:0] r2_ure, r2_uim;
    logic [PW-1:0]        r2_d;
    logic signed [VW-1:0] r2_vre, r2_vim;
    logic signed [SW-1:0] e0, e1, e2, e3;

    assign e0 = {r1_p0[PW-1], r1_p0};
    assign e1 = {r1_p1[PW-1], r1_p1};
    assign e2 = {r1_p2[PW-1], r1_p2};
    assign e3 = {r1_p3[PW-1], r1_p3};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_op  <= r1_op;
            r2_ure <= r1_op.mul ? e0 - e1 : e0 + e1;
            r2_uim <= r1_op.mul ? e2 + e3 : e3 - e2;
            r2_d   <= $unsigned(r1_p4) + $unsigned(r1_p5);
            r2_vre <= r1_vre;
            r2_vim <= r1_vim;
        end
    end

    // Stage 3 feeds the step pipeline at index 0.
    logic              r_sv   [0:NSTG];
    t_op               r_sop  [0:NSTG];
    logic [CW-1:0]     r_rre  [0:NSTG];
    logic [CW-1:0]     r_rim  [0:NSTG];
    logic [QW-1:0]     r_qre  [0:NSTG];
    logic [QW-1:0]     r_qim  [0:NSTG];
    logic [RW-1:0]     r_srem [0:NSTG];
    logic [W-1:0]      r_root [0:NSTG];
    logic [PW-1:0]     r_sd   [0:NSTG];
    logic              r_nre  [0:NSTG];
    logic              r_nim  [0:NSTG];
    logic              r_dz   [0:NSTG];
    logic signed [VW-1:0] r_svre [0:NSTG];
    logic signed [VW-1:0] r_svim [0:NSTG];

    logic signed [SW-1:0] mul_re, mul_im;
    logic [SW-1:0]        mag_re, mag_im;
    logic signed [VW-1:0] n3_vre, n3_vim;

    assign mul_re = r2_ure >>> F;
    assign mul_im = r2_uim >>> F;
    assign mag_re = r2_ure[SW-1] ? -r2_ure : r2_ure;
    assign mag_im = r2_uim[SW-1] ? -r2_uim : r2_uim;

    always_comb begin
        n3_vre = r2_vre;
        n3_vim = r2_vim;
        if (r2_op.mul) begin
            n3_vre = {{(VW-SW){mul_re[SW-1]}}, mul_re};
            n3_vim = {{(VW-SW){mul_im[SW-1]}}, mul_im};
        end else if (r2_op.abs2) begin
            n3_vre = {{(VW-PW){1'b0}}, r2_d >> F};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv[0] <= 1'b0;
        end else if (en) begin
            r_sv[0] <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sop[0]  <= r2_op;
            r_rre[0]  <= {{(CW-PW){1'b0}}, mag_re[PW-1:0]} << F;
            r_rim[0]  <= {{(CW-PW){1'b0}}, mag_im[PW-1:0]} << F;
            r_qre[0]  <= '0;
            r_qim[0]  <= '0;
            r_srem[0] <= {{(RW-PW){1'b0}}, r2_d};
            r_root[0] <= '0;
            r_sd[0]   <= r2_d;
            r_nre[0]  <= r2_ure[SW-1];
            r_nim[0]  <= r2_uim[SW-1];
            r_dz[0]   <= (r2_d == '0);
            r_svre[0] <= n3_vre;
            r_svim[0] <= n3_vim;
        end
    end

    // One quotient bit per stage for both parts; the stages that take no root
    // bit find quotients that are too large for the word. The root takes one bit
    // per stage in the remaining stages of the same pipeline.
    for (genvar j = 0; j < NSTG; j++) begin : g_step
        localparam int K = W + 1 - j;

        logic [CW-1:0] dk;
        logic          ge_re, ge_im;
        logic [RW-1:0] n_srem;
        logic [W-1:0]  n_root;

        assign dk    = {{(CW-PW){1'b0}}, r_sd[j]} << K;
        assign ge_re = (r_rre[j] >= dk);
        assign ge_im = (r_rim[j] >= dk);

        if (K < W) begin : g_root
            logic [RW-1:0] t;
            logic          ge_rt;
            assign t = ({{(RW-W){1'b0}}, r_root[j]} << (K + 1))
                     + ({{(RW-1){1'b0}}, 1'b1} << (2 * K));
            assign ge_rt  = (r_srem[j] >= t);
            assign n_srem = ge_rt ? r_srem[j] - t : r_srem[j];
            assign n_root = r_root[j] | (W'(ge_rt) << K);
        end else begin : g_noroot
            assign n_srem = r_srem[j];
            assign n_root = r_root[j];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[j+1] <= 1'b0;
            end else if (en) begin
                r_sv[j+1] <= r_sv[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sop[j+1]  <= r_sop[j];
                r_rre[j+1]  <= ge_re ? r_rre[j] - dk : r_rre[j];
                r_rim[j+1]  <= ge_im ? r_rim[j] - dk : r_rim[j];
                r_qre[j+1]  <= r_qre[j] | (QW'(ge_re) << K);
                r_qim[j+1]  <= r_qim[j] | (QW'(ge_im) << K);
                r_srem[j+1] <= n_srem;
                r_root[j+1] <= n_root;
                r_sd[j+1]   <= r_sd[j];
                r_nre[j+1]  <= r_nre[j];
                r_nim[j+1]  <= r_nim[j];
                r_dz[j+1]   <= r_dz[j];
                r_svre[j+1] <= r_svre[j];
                r_svim[j+1] <= r_svim[j];
            end
        end
    end

    // Final selection and saturation into the output register.
    logic signed [VW-1:0] q_re, q_im, f_re, f_im;
    logic [W:0]           s_re, s_im;
    logic                 f_dz;
    t_op                  l_op;

    assign l_op = r_sop[NSTG];
    assign q_re = {{(VW-QW){1'b0}}, r_qre[NSTG]};
    assign q_im = {{(VW-QW){1'b0}}, r_qim[NSTG]};
    assign f_dz = l_op.div && r_dz[NSTG];

    always_comb begin
        f_re = r_svre[NSTG];
        f_im = r_svim[NSTG];
        if (l_op.div) begin
            if (r_dz[NSTG]) begin
                f_re = '0;
                f_im = '0;
            end else begin
                f_re = r_nre[NSTG] ? -q_re : q_re;
                f_im = r_nim[NSTG] ? -q_im : q_im;
            end
        end else if (l_op.mag) begin
            f_re = {{(VW-W){1'b0}}, r_root[NSTG]};
            f_im = '0;
        end
    end

    assign s_re = sat_w(f_re);
    assign s_im = sat_w(f_im);

    logic                r_out_v;
    logic signed [W-1:0] r_res_re, r_res_im;
    logic                r_ov, r_dzo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= r_sv[NSTG];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_res_re <= s_re[W-1:0];
            r_res_im <= s_im[W-1:0];
            r_ov     <= s_re[W] | s_im[W];
            r_dzo    <= f_dz;
        end
    end

    assign o_res.valid    = r_out_v;
    assign o_res.res_re   = r_res_re;
    assign o_res.res_im   = r_res_im;
    assign o_res.overflow = r_ov;
    assign o_res.div_zero = r_dzo;

endmodule

// ===== design/complex_arithmetic_unit.sv =====
// Complex arithmetic unit on signed fixed-point operand pairs.
// Channel i_req carries mode and operands A and B; channel o_res carries the
// result parts and the overflow and divide-by-zero flags. Both channels use
// a valid/ready handshake and a request moves when both are high.
// One request is accepted per cycle and one result leaves per cycle while the
// receiver keeps ready high, with no state carried between requests. Results
// come out in request order. From acceptance a request passes the front
// register, the queue, the four product and sum stages and the WORD_WIDTH + 2
// division and square root step stages (one quotient bit per stage, and one
// root bit in every stage after the first two), after which the output
// register presents the result.
// While the receiver holds ready low on a presented result the back end halts
// as a whole; the queue of QUEUE_DEPTH requests and the front register keep
// accepting until full, after which i_req.ready falls. Reset empties every
// stage and the queue; no result is presented until a request has been taken.
// Depends on cau_pkg, cau_if, cau_front, cau_queue and cau_back.
module complex_arithmetic_unit import cau_pkg::*; #(
    parameter int WORD_WIDTH  = 32,
    parameter int FRAC_BITS   = 16,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cau_req_if.sink   i_req,
    cau_res_if.source o_res
);

    localparam int ITEM_W = $bits(t_op) + 4 * WORD_WIDTH;

    logic              fr_valid;
    logic [ITEM_W-1:0] fr_item;
    logic              fr_ready;
    logic              q_valid;
    logic [ITEM_W-1:0] q_item;
    logic              q_ready;

    cau_front #(
        .WORD_WIDTH (WORD_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_valid (fr_valid),
        .o_item  (fr_item),
        .i_ready (fr_ready)
    );

    cau_queue #(
        .DATA_W (ITEM_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fr_valid),
        .i_data  (fr_item),
        .o_ready (fr_ready),
        .o_valid (q_valid),
        .o_data  (q_item),
        .i_ready (q_ready)
    );

    cau_back #(
        .WORD_WIDTH (WORD_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_item  (q_item),
        .o_ready (q_ready),
        .o_res   (o_res)
    );

endmodule

// ===== test/complex_arithmetic_unit_tb.sv =====
// Testbench for the complex arithmetic unit: directed and random requests
// are checked against a fixed-point predictor, under varied handshake idling.
// Depends on cau_pkg, cau_if and the complex_arithmetic_unit RTL.
module complex_arithmetic_unit_tb;
    import cau_pkg::*;

    localparam int WW         = 32;
    localparam int FB         = 16;
    localparam int WD_LIMIT   = 3000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN      = 60;

    typedef struct packed {
        t_mode             mode;
        logic signed [WW-1:0] a_re;
        logic signed [WW-1:0] a_im;
        logic signed [WW-1:0] b_re;
        logic signed [WW-1:0] b_im;
    } t_req;

    typedef struct packed {
        logic signed [WW-1:0] res_re;
        logic signed [WW-1:0] res_im;
        logic                 overflow;
        logic                 div_zero;
    } t_res;

    localparam logic signed [WW-1:0] WMAX = {1'b0, {(WW-1){1'b1}}};
    localparam logic signed [WW-1:0] WMIN = {1'b1, {(WW-1){1'b0}}};

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    cau_req_if #(.WORD_WIDTH(WW)) req_if ();
    cau_res_if #(.WORD_WIDTH(WW)) res_if ();

    complex_arithmetic_unit #(.WORD_WIDTH(WW), .FRAC_BITS(FB)) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    t_res pending_results[$];
    int   fail_count = 0;
    int   req_count = 0;
    int   res_count = 0;
    int   ovf_count = 0;
    int   dz_count = 0;
    int   send_idle = 0;
    int   recv_idle = 0;
    int   hold_left = 0;
    int   quiet_cycles = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        req_if.valid = 1'b0;
        req_if.mode  = MODE_ADD;
        req_if.a_re  = '0;
        req_if.a_im  = '0;
        req_if.b_re  = '0;
        req_if.b_im  = '0;
        res_if.ready = 1'b0;
    end

    // Clamps a wide value to the word range and notes any saturation.
    function automatic logic signed [WW-1:0] clamp_word(input logic signed [127:0] v,
                                                        inout logic ov);
        if (v < $signed({{(128-WW){1'b1}}, WMIN})) begin
            ov = 1'b1;
            return WMIN;
        end
        if (v > $signed({{(128-WW){1'b0}}, WMAX})) begin
            ov = 1'b1;
            return WMAX;
        end
        return v[WW-1:0];
    endfunction

    function automatic logic [63:0] floor_root(input logic [63:0] n);
        logic [63:0] root;
        logic [63:0] bitv;
        root = '0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n    = n - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic t_res complex_result(input t_req r);
        logic signed [127:0] ar, ai, br, bi, re, im, den;
        logic ov;
        t_res o;
        ar = r.a_re;
        ai = r.a_im;
        br = r.b_re;
        bi = r.b_im;
        re = '0;
        im = '0;
        ov = 1'b0;
        o.div_zero = 1'b0;
        case (r.mode)
            MODE_ADD: begin
                re = ar + br;
                im = ai + bi;
            end
            MODE_SUB: begin
                re = ar - br;
                im = ai - bi;
            end
            MODE_MUL: begin
                re = (ar * br - ai * bi) >>> FB;
                im = (ar * bi + ai * br) >>> FB;
            end
            MODE_DIV: begin
                den = br * br + bi * bi;
                if (den == 0) begin
                    o.div_zero = 1'b1;
                end else begin
                    // Signed division in SystemVerilog truncates toward zero.
                    re = ((ar * br + ai * bi) <<< FB) / den;
                    im = ((ai * br - ar * bi) <<< FB) / den;
                end
            end
            MODE_CONJ: begin
                re = ar;
                im = -ai;
            end
            MODE_NEG: begin
                re = -ar;
                im = -ai;
            end
            MODE_ABS2: re = (ar * ar + ai * ai) >>> FB;
            default:   re = $signed({64'd0, floor_root(64'(ar * ar + ai * ai))});
        endcase
        o.res_re   = clamp_word(re, ov);
        o.res_im   = clamp_word(im, ov);
        o.overflow = ov;
        return o;
    endfunction

    function automatic logic signed [WW-1:0] pick_operand();
        case ($urandom_range(9))
            0:       return $urandom_range(1) ? WMAX : WMIN;
            1:       return $signed($urandom_range(3)) - 2;
            2, 3, 4: return $signed($urandom) >>> 10;
            5, 6:    return $signed($urandom) >>> 14;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_req random_request();
        t_req r;
        r.mode = t_mode'($urandom_range(7));
        r.a_re = pick_operand();
        r.a_im = pick_operand();
        r.b_re = pick_operand();
        r.b_im = pick_operand();
        if (r.mode == MODE_DIV && $urandom_range(19) == 0) begin
            r.b_re = '0;
            r.b_im = '0;
        end
        return r;
    endfunction

    // Offers one request, idling beforehand at the sender rate, and waits for it
    // to be taken. Valid stays high afterwards so back-to-back requests need
    // no extra assignment.
    task automatic send_request(input t_req r);
        while ($urandom_range(99) < send_idle) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.mode  <= r.mode;
        req_if.a_re  <= r.a_re;
        req_if.a_im  <= r.a_im;
        req_if.b_re  <= r.b_re;
        req_if.b_im  <= r.b_im;
        do @(posedge i_clk); while (!req_if.ready);
        pending_results.push_back(complex_result(r));
        req_count++;
    endtask

    task automatic send_ops(input t_mode m, input logic signed [WW-1:0] ar, ai, br, bi);
        t_req r;
        r = '{m, ar, ai, br, bi};
        send_request(r);
    endtask

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            res_if.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            res_if.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            res_count++;
            if (pending_results.size() == 0) begin
                $error("result arrived with nothing outstanding");
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (res_if.overflow) ovf_count++;
                if (res_if.div_zero) dz_count++;
                if (res_if.res_re !== want.res_re) begin
                    $error("res_re: expected %0d, got %0d", want.res_re, res_if.res_re);
                    fail_count++;
                end
                if (res_if.res_im !== want.res_im) begin
                    $error("res_im: expected %0d, got %0d", want.res_im, res_if.res_im);
                    fail_count++;
                end
                if (res_if.overflow !== want.overflow) begin
                    $error("overflow: expected %0b, got %0b", want.overflow,
                           res_if.overflow);
                    fail_count++;
                end
                if (res_if.div_zero !== want.div_zero) begin
                    $error("div_zero: expected %0b, got %0b", want.div_zero,
                           res_if.div_zero);
                    fail_count++;
                end
            end
        end
    end

    // Ends the run if neither channel moves for too long.
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)
            || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WD_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", WD_LIMIT);
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic test_directed();
        send_ops(MODE_ADD, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
        send_ops(MODE_ADD, WMAX, WMIN, WMAX, WMIN);
        send_ops(MODE_ADD, 32'sh0001_8000, -32'sh0002_0000, 32'sh0000_8000, 32'sd1);
        send_ops(MODE_SUB, WMIN, WMAX, WMAX, WMIN);
        send_ops(MODE_SUB, 32'sh0003_0000, 32'sd5, 32'sh0001_0000, -32'sd7);
        send_ops(MODE_MUL, WMAX, WMAX, WMAX, WMIN);
        send_ops(MODE_MUL, WMIN, WMIN, WMIN, WMIN);
        send_ops(MODE_MUL, 32'sh0002_0000, -32'sh0000_8000, -32'sd3, 32'sh0001_0000);
        send_ops(MODE_MUL, -32'sd1, 32'sd0, 32'sd1, 32'sd0);
        send_ops(MODE_DIV, 32'sh0004_0000, 32'sh0002_0000, 32'sh0001_0000, -32'sh0001_0000);
        send_ops(MODE_DIV, WMAX, WMIN, 32'sd0, 32'sd0);
        send_ops(MODE_DIV, WMAX, WMAX, 32'sd1, 32'sd0);
        send_ops(MODE_DIV, -32'sd7, 32'sd3, WMIN, WMIN);
        send_ops(MODE_DIV, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
        send_ops(MODE_CONJ, WMIN, WMIN, WMAX, WMAX);
        send_ops(MODE_CONJ, 32'sh0001_2345, -32'sh0000_4321, 32'sd0, 32'sd0);
        send_ops(MODE_NEG, WMIN, WMAX, WMIN, WMIN);
        send_ops(MODE_NEG, 32'sd5, -32'sd9, 32'sd0, 32'sd0);
        send_ops(MODE_ABS2, WMAX, WMIN, WMAX, WMAX);
        send_ops(MODE_ABS2, 32'sh0000_8000, -32'sh0001_0000, 32'sd0, 32'sd0);
        send_ops(MODE_ABS, WMIN, WMIN, WMIN, WMIN);
        send_ops(MODE_ABS, 32'sh0003_0000, -32'sh0004_0000, 32'sd0, 32'sd0);
        send_ops(MODE_ABS, 32'sd0, 32'sd0, WMAX, WMAX);
    endtask

    task automatic test_random(input int count, input int s_idle, input int r_idle);
        send_idle = s_idle;
        recv_idle = r_idle;
        repeat (count) send_request(random_request());
    endtask

    // The receiver stalls for a long stretch while requests keep coming, so the
    // internal queue fills and the input side has to push back.
    task automatic test_backpressure();
        send_idle = 0;
        recv_idle = 0;
        hold_left = HOLD_CYCLES;
        repeat (60) send_request(random_request());
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(430, 21, 58);
        test_random(430, 58, 21);
        test_backpressure();
        test_random(400, 0, 0);
        req_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        $display("covered %0d requests over all eight modes, %0d results checked",
                 req_count, res_count);
        $display("%0d saturated results, %0d divisions by zero, one long output stall",
                 ovf_count, dz_count);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
